### rtl/scpq_pkg.sv
// Types and codes shared by the stable four-class priority queue.
// No dependencies.
`default_nettype none

package scpq_pkg;

  localparam int ID_W  = 16;
  localparam int CLS_W = 2;
  localparam int OCC_OUT_W = 5;
  localparam int STAT_W = 2;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic             action;
    logic [ID_W-1:0]  arrival_id;
    logic [CLS_W-1:0] arrival_class;
  } scpq_in_t;

  typedef struct packed {
    logic                 served_valid;
    logic [ID_W-1:0]      served_id;
    logic [CLS_W-1:0]     served_class;
    logic [STAT_W-1:0]    status;
    logic [OCC_OUT_W-1:0] occupancy_out;
  } scpq_out_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CLS_W-1:0] cls;
  } scpq_entry_t;

  typedef struct packed {
    logic        enq;
    logic        deq;
    scpq_entry_t arrival;
  } scpq_ctrl_t;

endpackage

`default_nettype wire

### rtl/scpq_cell.sv
// One slot of the sorted shift chain: holds an entry, inserts or shifts.
// Depends on scpq_pkg.
`default_nettype none

module scpq_cell
  import scpq_pkg::*;
(
  input  wire logic        clk,
  input  wire scpq_ctrl_t  ctrl,
  input  wire logic        slot_valid,
  input  wire logic        left_stay,
  input  wire scpq_entry_t left_entry,
  input  wire scpq_entry_t right_entry,
  output logic             stay,
  output scpq_entry_t      entry
);

  scpq_entry_t entry_r, entry_nxt;

  assign stay  = slot_valid && (entry_r.cls <= ctrl.arrival.cls);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.deq) begin
      entry_nxt = right_entry;
    end else if (ctrl.enq && !stay) begin
      if (left_stay) begin
        entry_nxt = ctrl.arrival;
      end else begin
        entry_nxt = left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

### rtl/stable_class_priority_queue_top.sv
// A result strobes in the cycle after its request is accepted.
// Throughput: one request per cycle; busy is high only during reset and the
// cycle after it. Insert and remove update every cell of the chain together.
// Reset clears occupancy and the result strobe; slot contents stay undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Depends on scpq_pkg and scpq_cell.
`default_nettype none

module stable_class_priority_queue_top
  import scpq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire scpq_in_t  in_req,
  output logic           out_strobe,
  output scpq_out_t      out_result
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [OCC_W-1:0] FULL = OCC_W'(DEPTH);

  logic             rdy_r;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             strobe_r;
  scpq_out_t        result_r, result_nxt;

  logic       accept;
  logic       full, empty;
  scpq_ctrl_t ctrl;

  logic        stay [DEPTH];
  scpq_entry_t entry [DEPTH];

  assign busy   = ~rdy_r;
  assign accept = start && rdy_r;
  assign full   = (occ_r == FULL);
  assign empty  = (occ_r == '0);

  assign ctrl.enq = accept && (in_req.action == ACT_ENQUEUE) && !full;
  assign ctrl.deq = accept && (in_req.action == ACT_DEQUEUE) && !empty;
  assign ctrl.arrival.id  = in_req.arrival_id;
  assign ctrl.arrival.cls = in_req.arrival_class;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic        left_stay;
    scpq_entry_t left_entry, right_entry;

    if (i == 0) begin : g_first
      assign left_stay  = 1'b1;
      assign left_entry = ctrl.arrival;
    end else begin : g_mid
      assign left_stay  = stay[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = ctrl.arrival;
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    scpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .slot_valid  (occ_r > OCC_W'(i)),
      .left_stay   (left_stay),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .stay        (stay[i]),
      .entry       (entry[i])
    );
  end

  always_comb begin
    occ_nxt = occ_r;
    if (ctrl.enq) begin
      occ_nxt = occ_r + 1'b1;
    end else if (ctrl.deq) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_comb begin
    result_nxt = '0;
    if (in_req.action == ACT_ENQUEUE) begin
      result_nxt.status = full ? ST_OVERFLOW : ST_OK;
    end else if (empty) begin
      result_nxt.status = ST_UNDERFLOW;
    end else begin
      result_nxt.served_valid = 1'b1;
      result_nxt.served_id    = entry[0].id;
      result_nxt.served_class = entry[0].cls;
      result_nxt.status       = ST_OK;
    end
    result_nxt.occupancy_out = OCC_OUT_W'(32'(occ_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r    <= 1'b0;
      occ_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      rdy_r    <= 1'b1;
      occ_r    <= occ_nxt;
      strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_result = result_r;

`ifndef ASSERT_OFF
  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("result strobe missing after accepted request");

  a_no_spurious_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_strobe)
    else $error("result strobe without accepted request");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL)
    else $error("occupancy beyond depth");

  a_overflow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.action == ACT_ENQUEUE && full) |=>
      (out_result.status == ST_OVERFLOW && occ_r == FULL))
    else $error("overflow not flagged or queue changed");

  a_served_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.served_valid) |-> (out_result.status == ST_OK))
    else $error("served entry with bad status");
`endif

endmodule

`default_nettype wire

### bench/scpq_service_check.sv
`timescale 1ns / 100ps
// Checker for the stable four-class priority queue: keeps its own copy of the
// queue, predicts each result and compares it field by field.
// Depends on scpq_pkg.
module scpq_service_check
  import scpq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire scpq_in_t  in_req,
  input  wire logic      out_strobe,
  input  wire scpq_out_t out_result,
  output int             mismatches,
  output int             outstanding
);

  logic [ID_W-1:0]  shadow_id  [DEPTH];
  logic [CLS_W-1:0] shadow_cls [DEPTH];
  int               shadow_len;
  scpq_out_t        due_q[$];

  function automatic scpq_out_t serve_request(scpq_in_t req);
    scpq_out_t res;
    int        pos;
    res = '0;
    if (req.action == ACT_ENQUEUE) begin
      if (shadow_len >= DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < shadow_len && shadow_cls[pos] <= req.arrival_class) pos++;
        for (int k = shadow_len; k > pos; k--) begin
          shadow_id[k]  = shadow_id[k-1];
          shadow_cls[k] = shadow_cls[k-1];
        end
        shadow_id[pos]  = req.arrival_id;
        shadow_cls[pos] = req.arrival_class;
        shadow_len++;
        res.status = ST_OK;
      end
    end else if (shadow_len == 0) begin
      res.status = ST_UNDERFLOW;
    end else begin
      res.served_valid = 1'b1;
      res.served_id    = shadow_id[0];
      res.served_class = shadow_cls[0];
      for (int k = 1; k < shadow_len; k++) begin
        shadow_id[k-1]  = shadow_id[k];
        shadow_cls[k-1] = shadow_cls[k];
      end
      shadow_len--;
      res.status = ST_OK;
    end
    res.occupancy_out = OCC_OUT_W'(shadow_len);
    return res;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
    shadow_len  = 0;
  end

  always @(posedge clk) begin : watch
    scpq_out_t due;
    if (!rst_n) begin
      shadow_len = 0;
      due_q.delete();
    end else begin
      if (out_strobe) begin
        if (due_q.size() == 0) begin
          $error("result with no pending request: %p", out_result);
          mismatches++;
        end else begin
          due = due_q.pop_front();
          if (out_result.served_valid !== due.served_valid) begin
            $error("served_valid: expected %0d, actual %0d",
                   due.served_valid, out_result.served_valid);
            mismatches++;
          end
          if (out_result.served_id !== due.served_id) begin
            $error("served_id: expected %0h, actual %0h",
                   due.served_id, out_result.served_id);
            mismatches++;
          end
          if (out_result.served_class !== due.served_class) begin
            $error("served_class: expected %0d, actual %0d",
                   due.served_class, out_result.served_class);
            mismatches++;
          end
          if (out_result.status !== due.status) begin
            $error("status: expected %0d, actual %0d", due.status, out_result.status);
            mismatches++;
          end
          if (out_result.occupancy_out !== due.occupancy_out) begin
            $error("occupancy_out: expected %0d, actual %0d",
                   due.occupancy_out, out_result.occupancy_out);
            mismatches++;
          end
        end
      end
      if (start && !busy) due_q.push_back(serve_request(in_req));
    end
    outstanding = due_q.size();
  end

endmodule

### bench/stable_class_priority_queue_top_test.sv
`timescale 1ns / 100ps
// Top of the priority queue bench: drives requests with random gaps and gives
// the verdict. Depends on scpq_pkg, the queue top and scpq_service_check.
module stable_class_priority_queue_top_test
  import scpq_pkg::*;
();

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk    = 1'b0;
  logic      rst_n  = 1'b0;
  logic      start  = 1'b0;
  scpq_in_t  in_req = '0;
  logic      busy;
  logic      out_strobe;
  scpq_out_t out_result;
  int        mismatches;
  int        outstanding;
  int        cycle_count = 0;
  int        steady_left = 0;

  stable_class_priority_queue_top #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

  scpq_service_check #(.DEPTH(DEPTH)) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_strobe  (out_strobe),
    .out_result  (out_result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic scpq_in_t random_request();
    scpq_in_t req;
    req.action        = 1'($urandom_range(0, 1));
    req.arrival_id    = ID_W'($urandom_range(0, 65535));
    req.arrival_class = CLS_W'($urandom_range(0, 3));
    return req;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      steady_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  task automatic issue(scpq_in_t req);
    @(negedge clk);
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start  <= 1'b0;
      in_req <= random_request();
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    scpq_in_t req;
    int       enq_pct;
    int       cls_lo;
    int       cls_hi;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    req = random_request();
    req.action = ACT_DEQUEUE;
    issue(req);
    for (int i = 0; i < DEPTH + 1; i++) begin
      req.action        = ACT_ENQUEUE;
      req.arrival_id    = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom);
      req.arrival_class = CLS_W'((i * 3) % 4);
      issue(req);
    end
    for (int i = 0; i < 5; i++) begin
      req = random_request();
      req.action = ACT_DEQUEUE;
      issue(req);
    end

    enq_pct = 50;
    cls_lo  = 0;
    cls_hi  = 3;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       enq_pct = 25;
          1:       enq_pct = 50;
          2:       enq_pct = 75;
          default: enq_pct = 95;
        endcase
        if ($urandom_range(0, 2) == 0) begin
          cls_lo = $urandom_range(0, 3);
          cls_hi = $urandom_range(cls_lo, 3);
        end else begin
          cls_lo = 0;
          cls_hi = 3;
        end
      end
      if (n == RANDOM_ITEMS / 4 || n == RANDOM_ITEMS / 2) drain();
      hold_off(pick_gap());
      req = random_request();
      req.action = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
      if (req.action == ACT_ENQUEUE) begin
        req.arrival_class = CLS_W'($urandom_range(cls_lo, cls_hi));
      end
      issue(req);
    end

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
